@@ rtl/nfls_pkg.sv @@
// Shared constants, codes and types of the nearest fogged light selector.
package nfls_pkg;

  // Field and register widths
  localparam int POS_W      = 24;
  localparam int ZONE_W     = 8;
  localparam int RADIUS_W   = 8;
  localparam int CMD_W      = 2;
  localparam int IDX_W      = 16;
  localparam int CNT_W      = 17;
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int ZCNT_W     = 9;
  localparam int FOG_WORDS  = 4;
  localparam int FOG_BITS   = FOG_WORDS * CFG_W;

  // Sizing
  localparam int CAPACITY   = 8;
  localparam int MAX_LIGHTS = 4096;
  localparam int COORD_BITS = 24;

  // Derived widths
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int MAG_W   = DIFF_W;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int DIST_W  = SQ_W + 2;
  localparam int SLOT_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int KEPT_W  = $clog2(CAPACITY + 1);
  localparam int ARR_W   = $clog2(MAX_LIGHTS + 1);

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Request commands
  localparam logic [CMD_W-1:0] CMD_BEGIN = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LIGHT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_END   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FOG_LO     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOG_MID_LO = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FOG_MID_HI = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FOG_HI     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZONE_COUNT = 3'd4;

  // Operation kinds carried through the queue
  localparam logic [1:0] OP_BEGIN = 2'd0;
  localparam logic [1:0] OP_LIGHT = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic [1:0]       kind;
    coord_t           pos_x;
    coord_t           pos_y;
    coord_t           pos_z;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] count;
  } op_t;

  // Field bits read as a COORD_BITS two's complement value
  function automatic coord_t coord_of(input logic [POS_W-1:0] raw);
    return coord_t'(COORD_BITS'(raw));
  endfunction

endpackage

@@ rtl/nearest_fogged_light_select_top.sv @@
// Top level of the nearest fogged light selector.
//
// Requests arrive on the in_ channel (valid/ready): begin latches the eye and
// camera zone, light offers one light, end asks for the result list. Results
// leave on the out_ channel (valid/ready), one per kept light, nearest first,
// with out_last on the final one; an empty selection gives one result with
// out_has_index low. Registers are written through cfg_we/cfg_index/cfg_wdata;
// the user must write them only while the block is idle; it is not enforced.
// The front end classifies one request per cycle, while the queue is not full,
// into a two-entry queue. The back end takes a begin in its idle state, a light
// as a pop, three squares and a final sum through one shared multiplier and an
// insert step, and an end as one result per cycle while the receiver takes them,
// or one result for an empty selection; that shared multiplier sets the light
// rate. Lights that are not candidates never enter the queue. An end's first
// result passes its queue entry, the emit state and the output register.
// Reset (synchronous, rst_n low) clears registers, counters and the kept list.
// A stalled receiver holds the output register; the back end and then the
// queue fill, and in_ready drops.
module nearest_fogged_light_select_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [nfls_pkg::CMD_W-1:0]        in_cmd,
  input  logic signed [nfls_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [nfls_pkg::POS_W-1:0] in_pos_y,
  input  logic signed [nfls_pkg::POS_W-1:0] in_pos_z,
  input  logic [nfls_pkg::ZONE_W-1:0]       in_zone,
  input  logic [nfls_pkg::RADIUS_W-1:0]     in_volume_radius,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [nfls_pkg::IDX_W-1:0]        out_light_index,
  output logic                              out_has_index,
  output logic [nfls_pkg::CNT_W-1:0]        out_dropped,
  output logic                              out_last,
  input  logic                              cfg_we,
  input  logic [nfls_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nfls_pkg::CFG_W-1:0]        cfg_wdata
);

  logic          q_push, q_full, q_pop, q_empty;
  nfls_pkg::op_t q_op, q_head;

  nfls_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_pos_z         (in_pos_z),
    .in_zone          (in_zone),
    .in_volume_radius (in_volume_radius),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_op             (q_op)
  );

  nfls_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (q_op),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .head_op (q_head)
  );

  nfls_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .q_head          (q_head),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_light_index (out_light_index),
    .out_has_index   (out_has_index),
    .out_dropped     (out_dropped),
    .out_last        (out_last)
  );

`ifndef SYNTHESIS
  // Queue is never written while full
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("queue push while full");

  // Queue is never read while empty
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue pop while empty");

  // Empty selection is a single final result with nothing dropped
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_has_index) |-> (out_last && (out_light_index == '0)
                                       && (out_dropped == '0)))
    else $error("malformed empty selection result");
`endif

endmodule

@@ rtl/nfls_front.sv @@
// Front end: configuration, request classification and per-frame counters.
module nfls_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [nfls_pkg::CMD_W-1:0]        in_cmd,
  input  logic signed [nfls_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [nfls_pkg::POS_W-1:0] in_pos_y,
  input  logic signed [nfls_pkg::POS_W-1:0] in_pos_z,
  input  logic [nfls_pkg::ZONE_W-1:0]       in_zone,
  input  logic [nfls_pkg::RADIUS_W-1:0]     in_volume_radius,
  input  logic                              cfg_we,
  input  logic [nfls_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nfls_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                              q_full,
  output logic                              q_push,
  output nfls_pkg::op_t                     q_op
);

  logic [nfls_pkg::FOG_BITS-1:0] fog_r;
  logic [nfls_pkg::ZCNT_W-1:0]   zone_count_r;
  logic                          camera_foggy_r, camera_foggy_nxt;
  logic [nfls_pkg::ARR_W-1:0]    arrival_r, arrival_nxt;
  logic [nfls_pkg::CNT_W-1:0]    cand_r, cand_nxt;
  logic                          accept;
  logic                          zone_is_foggy;
  logic [nfls_pkg::ZONE_W-1:0]   zone_sel;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fog_r        <= '0;
      zone_count_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        nfls_pkg::REG_FOG_LO:     fog_r[0*nfls_pkg::CFG_W +: nfls_pkg::CFG_W] <= cfg_wdata;
        nfls_pkg::REG_FOG_MID_LO: fog_r[1*nfls_pkg::CFG_W +: nfls_pkg::CFG_W] <= cfg_wdata;
        nfls_pkg::REG_FOG_MID_HI: fog_r[2*nfls_pkg::CFG_W +: nfls_pkg::CFG_W] <= cfg_wdata;
        nfls_pkg::REG_FOG_HI:     fog_r[3*nfls_pkg::CFG_W +: nfls_pkg::CFG_W] <= cfg_wdata;
        nfls_pkg::REG_ZONE_COUNT: zone_count_r <= cfg_wdata[nfls_pkg::ZCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Fog test: out-of-range zones fall back to zone 0
  assign zone_sel = ({1'b0, in_zone} >= zone_count_r) ? '0 : in_zone;
  assign zone_is_foggy = (zone_count_r != '0) && fog_r[zone_sel];

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Classify the request and build the queue entry
  always_comb begin
    camera_foggy_nxt = camera_foggy_r;
    arrival_nxt      = arrival_r;
    cand_nxt         = cand_r;
    q_push           = 1'b0;
    q_op.kind        = nfls_pkg::OP_END;
    q_op.pos_x       = nfls_pkg::coord_of(in_pos_x);
    q_op.pos_y       = nfls_pkg::coord_of(in_pos_y);
    q_op.pos_z       = nfls_pkg::coord_of(in_pos_z);
    q_op.idx         = nfls_pkg::IDX_W'(arrival_r);
    q_op.count       = cand_r;
    if (accept) begin
      case (in_cmd)
        nfls_pkg::CMD_BEGIN: begin
          camera_foggy_nxt = zone_is_foggy;
          arrival_nxt      = '0;
          cand_nxt         = '0;
          q_push           = 1'b1;
          q_op.kind        = nfls_pkg::OP_BEGIN;
        end
        nfls_pkg::CMD_LIGHT: begin
          if (arrival_r < nfls_pkg::ARR_W'(nfls_pkg::MAX_LIGHTS)) begin
            arrival_nxt = arrival_r + 1'b1;
            if (camera_foggy_r && (in_volume_radius != '0) && zone_is_foggy) begin
              q_push    = 1'b1;
              q_op.kind = nfls_pkg::OP_LIGHT;
              if (cand_r != {nfls_pkg::CNT_W{1'b1}}) begin
                cand_nxt = cand_r + 1'b1;
              end
            end
          end
        end
        nfls_pkg::CMD_END: begin
          q_push    = 1'b1;
          q_op.kind = nfls_pkg::OP_END;
        end
        default: ;
      endcase
    end
  end

  // Frame counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      camera_foggy_r <= 1'b0;
      arrival_r      <= '0;
      cand_r         <= '0;
    end else begin
      camera_foggy_r <= camera_foggy_nxt;
      arrival_r      <= arrival_nxt;
      cand_r         <= cand_nxt;
    end
  end

endmodule

@@ rtl/nfls_queue.sv @@
// Short register queue of classified operations between front and back.
module nfls_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  nfls_pkg::op_t push_op,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output nfls_pkg::op_t head_op
);

  nfls_pkg::op_t                entry_r [nfls_pkg::QUEUE_DEPTH];
  logic [nfls_pkg::QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [nfls_pkg::QCNT_W-1:0]  count_r;

  localparam logic [nfls_pkg::QPTR_W-1:0] LAST_PTR = nfls_pkg::QPTR_W'(nfls_pkg::QUEUE_DEPTH - 1);

  assign full    = (count_r == nfls_pkg::QCNT_W'(nfls_pkg::QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign head_op = entry_r[rd_ptr_r];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_op;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/nfls_back.sv @@
// Back end: squared distance, sorted insertion chain and result sequencing.
module nfls_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  output logic                          q_pop,
  input  nfls_pkg::op_t                 q_head,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [nfls_pkg::IDX_W-1:0]    out_light_index,
  output logic                          out_has_index,
  output logic [nfls_pkg::CNT_W-1:0]    out_dropped,
  output logic                          out_last
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SQUARE = 2'd1;
  localparam logic [1:0] ST_INSERT = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  localparam int CAP = nfls_pkg::CAPACITY;

  logic [1:0]                         state_r;
  nfls_pkg::coord_t                   eye_x_r, eye_y_r, eye_z_r;
  logic signed [nfls_pkg::DIFF_W-1:0] diff_x_r, diff_y_r, diff_z_r, diff_sel;
  logic [1:0]                         step_r;
  logic [nfls_pkg::MAG_W-1:0]         mag;
  logic [nfls_pkg::SQ_W-1:0]          prod_r;
  logic [nfls_pkg::DIST_W-1:0]        acc_r;
  logic [nfls_pkg::IDX_W-1:0]         idx_r;

  logic [nfls_pkg::DIST_W-1:0]        slot_dist_r [CAP];
  logic [nfls_pkg::IDX_W-1:0]         slot_idx_r  [CAP];
  logic [CAP-1:0]                     slot_valid_r;
  logic [nfls_pkg::DIST_W-1:0]        slot_dist_nxt [CAP];
  logic [nfls_pkg::IDX_W-1:0]         slot_idx_nxt  [CAP];
  logic [CAP-1:0]                     slot_valid_nxt;
  logic [CAP-1:0]                     lt, lt_prev;

  logic [nfls_pkg::KEPT_W-1:0]        kept_now, kept_r, emit_ptr_r;
  logic [nfls_pkg::CNT_W-1:0]         dropped_now, dropped_r;
  logic                               out_free, emit_last;

  logic                               out_valid_r;
  logic [nfls_pkg::IDX_W-1:0]         out_idx_r;
  logic                               out_has_r, out_last_r;
  logic [nfls_pkg::CNT_W-1:0]         out_dropped_r;

  assign q_pop = (state_r == ST_IDLE) && !q_empty;

  // Kept count and overflow count at end of frame
  assign kept_now    = nfls_pkg::KEPT_W'($countones(slot_valid_r));
  assign dropped_now = (q_head.count > nfls_pkg::CNT_W'(kept_now)) ?
                       q_head.count - nfls_pkg::CNT_W'(kept_now) : '0;

  // One axis squared per cycle through a shared multiplier
  always_comb begin
    case (step_r)
      2'd0:    diff_sel = diff_x_r;
      2'd1:    diff_sel = diff_y_r;
      default: diff_sel = diff_z_r;
    endcase
    mag = diff_sel[nfls_pkg::DIFF_W-1] ? nfls_pkg::MAG_W'(-diff_sel)
                                       : nfls_pkg::MAG_W'(diff_sel);
  end

  // Insertion chain: new entry goes ahead of the first strictly farther slot
  always_comb begin
    for (int k = 0; k < CAP; k++) begin
      lt[k] = !slot_valid_r[k] || (acc_r < slot_dist_r[k]);
    end
    lt_prev = lt << 1;
    for (int k = 0; k < CAP; k++) begin
      if (lt_prev[k]) begin
        slot_dist_nxt[k]  = slot_dist_r[k - ((k == 0) ? 0 : 1)];
        slot_idx_nxt[k]   = slot_idx_r[k - ((k == 0) ? 0 : 1)];
        slot_valid_nxt[k] = slot_valid_r[k - ((k == 0) ? 0 : 1)];
      end else if (lt[k]) begin
        slot_dist_nxt[k]  = acc_r;
        slot_idx_nxt[k]   = idx_r;
        slot_valid_nxt[k] = 1'b1;
      end else begin
        slot_dist_nxt[k]  = slot_dist_r[k];
        slot_idx_nxt[k]   = slot_idx_r[k];
        slot_valid_nxt[k] = slot_valid_r[k];
      end
    end
  end

  assign out_free  = !out_valid_r || out_ready;
  assign emit_last = (kept_r == '0) || (emit_ptr_r == kept_r - 1'b1);

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      slot_valid_r <= '0;
      eye_x_r      <= '0;
      eye_y_r      <= '0;
      eye_z_r      <= '0;
      step_r       <= '0;
      emit_ptr_r   <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            case (q_head.kind)
              nfls_pkg::OP_BEGIN: begin
                eye_x_r      <= q_head.pos_x;
                eye_y_r      <= q_head.pos_y;
                eye_z_r      <= q_head.pos_z;
                slot_valid_r <= '0;
              end
              nfls_pkg::OP_LIGHT: begin
                step_r  <= '0;
                state_r <= ST_SQUARE;
              end
              nfls_pkg::OP_END: begin
                emit_ptr_r <= '0;
                state_r    <= ST_EMIT;
              end
              default: ;
            endcase
          end
        end
        ST_SQUARE: begin
          step_r <= step_r + 1'b1;
          if (step_r == 2'd3) begin
            state_r <= ST_INSERT;
          end
        end
        ST_INSERT: begin
          slot_valid_r <= slot_valid_nxt;
          state_r      <= ST_IDLE;
        end
        ST_EMIT: begin
          if (out_free) begin
            emit_ptr_r <= emit_ptr_r + 1'b1;
            if (emit_last) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (q_pop && (q_head.kind == nfls_pkg::OP_LIGHT)) begin
      diff_x_r <= nfls_pkg::DIFF_W'(q_head.pos_x) - nfls_pkg::DIFF_W'(eye_x_r);
      diff_y_r <= nfls_pkg::DIFF_W'(q_head.pos_y) - nfls_pkg::DIFF_W'(eye_y_r);
      diff_z_r <= nfls_pkg::DIFF_W'(q_head.pos_z) - nfls_pkg::DIFF_W'(eye_z_r);
      idx_r    <= q_head.idx;
    end
    if (q_pop && (q_head.kind == nfls_pkg::OP_END)) begin
      kept_r    <= kept_now;
      dropped_r <= dropped_now;
    end
    if (state_r == ST_SQUARE) begin
      prod_r <= mag * mag;
      if (step_r == 2'd0) begin
        acc_r <= '0;
      end else begin
        acc_r <= acc_r + nfls_pkg::DIST_W'(prod_r);
      end
    end
    if (state_r == ST_INSERT) begin
      slot_dist_r <= slot_dist_nxt;
      slot_idx_r  <= slot_idx_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_EMIT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_EMIT) && out_free) begin
      out_has_r     <= (kept_r != '0);
      out_idx_r     <= (kept_r != '0) ? slot_idx_r[emit_ptr_r[nfls_pkg::SLOT_W-1:0]] : '0;
      out_dropped_r <= dropped_r;
      out_last_r    <= emit_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_light_index = out_idx_r;
  assign out_has_index   = out_has_r;
  assign out_dropped     = out_dropped_r;
  assign out_last        = out_last_r;

endmodule
